### rtl/accel_motion_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// accel_motion_detector_unit assertion macros
// Shared concurrent assertion wrappers; the including module supplies
// i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MOTION_DETECTOR_UNIT_MACROS_SVH
`define ACCEL_MOTION_DETECTOR_UNIT_MACROS_SVH

// Plain property, checked on every clock outside reset.
`define AMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    `AMD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// amd_pkg
// Types, constants and helpers shared by the motion detector modules.
// ----------------------------------------------------------------------------
package amd_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ADDR_W    = 4;
    localparam int MAG_W     = 24;

    localparam logic [15:0]      RST_PERIOD = 16'd100;
    localparam logic [15:0]      RST_ALPHA  = 16'd13107;
    localparam logic [MAG_W-1:0] RST_THRESH = 24'd12800;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_ALPHA  = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_WAKE,
        CMD_IDLE,
        CMD_FAIL,
        CMD_SAMPLE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_cmd;

    typedef struct packed {
        logic [15:0]      sample_period_ms;
        logic [15:0]      filter_alpha;
        logic [MAG_W-1:0] movement_threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_ROOT,
        B_FILTER,
        B_UPDATE,
        B_COMPARE,
        B_DONE
    } t_bstate;

    // root << FRAC_BITS, saturated to the magnitude width
    function automatic logic [MAG_W-1:0] mag_from_root(input logic [15:0] root);
        logic [39:0] w;
        w = {24'b0, root} << FRAC_BITS;
        if (|w[39:MAG_W]) begin
            return '1;
        end
        return w[MAG_W-1:0];
    endfunction

endpackage

### rtl/amd_cmdq.sv
// ----------------------------------------------------------------------------
// amd_cmdq
// Two-entry command queue between the classifier and the sample engine.
// ----------------------------------------------------------------------------
module amd_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  amd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output amd_pkg::t_cmd o_head
);

    amd_pkg::t_cmd r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/amd_front.sv
// ----------------------------------------------------------------------------
// amd_front
// Accepts items, runs the sample period counter and classifies each item.
// ----------------------------------------------------------------------------
module amd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_mode,
    input  logic [15:0]        i_elapsed_ms,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_read_ok,
    input  amd_pkg::t_cfg      i_cfg,
    input  logic               i_q_full,
    output logic               o_q_push,
    output amd_pkg::t_cmd      o_q_cmd
);

    logic [31:0] r_period_count;
    logic [31:0] n_period_count;
    logic [32:0] sum;
    logic [31:0] sat;
    logic        due;

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        sum = {1'b0, r_period_count} + {17'b0, i_elapsed_ms};
        sat = sum[32] ? '1 : sum[31:0];
        due = (sat >= {16'b0, i_cfg.sample_period_ms});
    end

    always_comb begin
        o_q_cmd.x = i_accel_x;
        o_q_cmd.y = i_accel_y;
        o_q_cmd.z = i_accel_z;
        priority if (i_mode) begin
            o_q_cmd.kind = amd_pkg::CMD_WAKE;
        end else if (!due) begin
            o_q_cmd.kind = amd_pkg::CMD_IDLE;
        end else if (!i_read_ok) begin
            o_q_cmd.kind = amd_pkg::CMD_FAIL;
        end else begin
            o_q_cmd.kind = amd_pkg::CMD_SAMPLE;
        end
    end

    // wake and any due beat, good or failed read, restart the period
    always_comb begin
        n_period_count = r_period_count;
        if (o_q_push) begin
            n_period_count = (i_mode || due) ? 32'd0 : sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_count <= 32'd0;
        end else begin
            r_period_count <= n_period_count;
        end
    end

endmodule

### rtl/amd_back.sv
// ----------------------------------------------------------------------------
// amd_back
// Sample engine: sum of squares, iterative square root, EMA filter,
// movement decision and the result register.
// ----------------------------------------------------------------------------
`include "accel_motion_detector_unit_macros.svh"

module amd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  amd_pkg::t_cfg              i_cfg,
    input  logic                       i_q_empty,
    input  amd_pkg::t_cmd              i_q_head,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic                       o_movement,
    output logic                       o_sample_taken,
    output logic                       o_read_failed,
    output logic [amd_pkg::MAG_W-1:0]  o_filtered_magnitude
);

    amd_pkg::t_bstate r_state;
    amd_pkg::t_bstate n_state;

    amd_pkg::t_cmd_kind r_kind;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic [1:0]         r_sq_idx;
    logic [31:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_bit;
    logic signed [41:0] r_prod;
    logic [amd_pkg::MAG_W-1:0] r_new;

    logic [amd_pkg::MAG_W-1:0] r_filt;
    logic                      r_seeded;
    logic                      r_move;

    logic                      r_res_valid;
    logic                      r_res_move;
    logic                      r_res_taken;
    logic                      r_res_failed;
    logic [amd_pkg::MAG_W-1:0] r_res_filt;

    logic                      res_load;
    logic signed [15:0]        sq_op;
    logic [15:0]               sq_abs;
    logic [31:0]               sq;
    logic [31:0]               trial;
    logic [amd_pkg::MAG_W-1:0] mag;
    logic signed [24:0]        diff;
    logic signed [41:0]        prod;
    logic signed [25:0]        q;
    logic signed [26:0]        nv;
    logic [amd_pkg::MAG_W-1:0] nv_clamp;
    logic [amd_pkg::MAG_W-1:0] delta;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amd_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_head.kind == amd_pkg::CMD_SAMPLE) ?
                              amd_pkg::B_SQUARE : amd_pkg::B_DONE;
                end
            end
            amd_pkg::B_SQUARE: begin
                if (r_sq_idx == 2'd2) begin
                    n_state = amd_pkg::B_ROOT;
                end
            end
            amd_pkg::B_ROOT: begin
                if (r_bit[0]) begin
                    n_state = amd_pkg::B_FILTER;
                end
            end
            amd_pkg::B_FILTER: begin
                n_state = r_seeded ? amd_pkg::B_UPDATE : amd_pkg::B_DONE;
            end
            amd_pkg::B_UPDATE: begin
                n_state = amd_pkg::B_COMPARE;
            end
            amd_pkg::B_COMPARE: begin
                n_state = amd_pkg::B_DONE;
            end
            amd_pkg::B_DONE: begin
                if (res_load) begin
                    n_state = amd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = amd_pkg::B_IDLE;
            end
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_q_pop  = (r_state == amd_pkg::B_IDLE) && !i_q_empty;
        res_load = (r_state == amd_pkg::B_DONE) && (!r_res_valid || i_pop);
    end

    assign o_empty              = !r_res_valid;
    assign o_movement           = r_res_move;
    assign o_sample_taken       = r_res_taken;
    assign o_read_failed        = r_res_failed;
    assign o_filtered_magnitude = r_res_filt;

    // ---------------- datapath ----------------
    always_comb begin
        unique case (r_sq_idx)
            2'd0:    sq_op = r_x;
            2'd1:    sq_op = r_y;
            default: sq_op = r_z;
        endcase
        sq_abs = sq_op[15] ? 16'(-sq_op) : 16'(sq_op);
        sq     = sq_abs * sq_abs;
        trial  = r_root + r_bit;
    end

    always_comb begin
        mag  = amd_pkg::mag_from_root(r_root[15:0]);
        diff = $signed({1'b0, mag}) - $signed({1'b0, r_filt});
        prod = $signed({1'b0, i_cfg.filter_alpha}) * diff;
    end

    // floor shift, then clamp to the 24-bit range
    always_comb begin
        q  = r_prod[41:16];
        nv = $signed({3'b0, r_filt}) + 27'(q);
        if (nv < 0) begin
            nv_clamp = '0;
        end else if (nv > $signed({3'b0, {amd_pkg::MAG_W{1'b1}}})) begin
            nv_clamp = '1;
        end else begin
            nv_clamp = nv[amd_pkg::MAG_W-1:0];
        end
        delta = (r_new >= r_filt) ? (r_new - r_filt) : (r_filt - r_new);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amd_pkg::B_IDLE;
            r_filt      <= '0;
            r_seeded    <= 1'b0;
            r_move      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop && (i_q_head.kind == amd_pkg::CMD_WAKE)) begin
                r_seeded <= 1'b0;
            end
            if (r_state == amd_pkg::B_FILTER && !r_seeded) begin
                r_filt   <= mag;
                r_seeded <= 1'b1;
                r_move   <= 1'b0;
            end
            if (r_state == amd_pkg::B_COMPARE) begin
                r_move <= (delta > i_cfg.movement_threshold);
                r_filt <= r_new;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind   <= i_q_head.kind;
            r_x      <= i_q_head.x;
            r_y      <= i_q_head.y;
            r_z      <= i_q_head.z;
            r_sq_idx <= 2'd0;
            r_rem    <= 32'd0;
        end
        if (r_state == amd_pkg::B_SQUARE) begin
            r_rem    <= r_rem + sq;
            r_sq_idx <= r_sq_idx + 2'd1;
            r_root   <= 32'd0;
            r_bit    <= 32'h4000_0000;
        end
        if (r_state == amd_pkg::B_ROOT) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == amd_pkg::B_FILTER) begin
            r_prod <= prod;
        end
        if (r_state == amd_pkg::B_UPDATE) begin
            r_new <= nv_clamp;
        end
        if (res_load) begin
            r_res_move   <= r_move;
            r_res_taken  <= (r_kind == amd_pkg::CMD_SAMPLE);
            r_res_failed <= (r_kind == amd_pkg::CMD_FAIL);
            r_res_filt   <= r_filt;
        end
    end

    // ---------------- assertions ----------------
    `AMD_ASSERT_NEXT(a_res_held, r_res_valid && !i_pop, r_res_valid, "result beat lost")
    `AMD_ASSERT(a_root_bit, (r_state == amd_pkg::B_ROOT) |-> $onehot(r_bit), "root bit lost")
    `AMD_ASSERT(a_upd_seeded, (r_state == amd_pkg::B_UPDATE) |-> r_seeded, "update unseeded")
    `AMD_ASSERT(a_flags_excl, r_res_valid |-> !(r_res_taken && r_res_failed), "taken and failed")

endmodule

### rtl/accel_motion_detector_unit.sv
// ----------------------------------------------------------------------------
// accel_motion_detector_unit
// Accelerometer magnitude EMA motion detector with APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats enter through push/full (mode, elapsed_ms, accel_x/y/z,
//   read_ok); one result beat per input leaves through empty/pop
//   (movement, sample_taken, read_failed, filtered_magnitude), in order.
//   Registers: 0x0 sample_period_ms, 0x4 filter_alpha, 0x8
//   movement_threshold; write them only while the block is idle.
//   A wake, not-due or failed-read beat passes from the command queue through
//   the engine's idle and done states into the result register; a good sample
//   also runs the sum-of-squares pass over x, y and z, the 16-step square
//   root loop and the filter state, then the update and compare states
//   unless it seeds the filter. The engine takes one beat at a time and pops
//   the next only once the last is in the result register; the 2-entry command
//   queue lets the input side keep taking beats while the engine works.
//   Reset (synchronous, i_rst_n low) loads the register defaults, clears the
//   period counter, filter value, seeded and movement flags, and empties
//   the command queue and the result register. When the receiver stalls, the
//   result register holds its beat, the engine waits in its final state, the
//   command queue fills and full rises.
// ----------------------------------------------------------------------------
module accel_motion_detector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [amd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        push,
    output logic                        full,
    input  logic                        i_mode,
    input  logic [15:0]                 i_elapsed_ms,
    input  logic signed [15:0]          i_accel_x,
    input  logic signed [15:0]          i_accel_y,
    input  logic signed [15:0]          i_accel_z,
    input  logic                        i_read_ok,
    // result channel
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_movement,
    output logic                        o_sample_taken,
    output logic                        o_read_failed,
    output logic [amd_pkg::MAG_W-1:0]   o_filtered_magnitude
);

    amd_pkg::t_cfg    r_cfg;
    amd_pkg::t_reg_idx reg_idx;
    logic             cfg_wr;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    amd_pkg::t_cmd    q_in;
    amd_pkg::t_cmd    q_head;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = amd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period_ms   <= amd_pkg::RST_PERIOD;
            r_cfg.filter_alpha       <= amd_pkg::RST_ALPHA;
            r_cfg.movement_threshold <= amd_pkg::RST_THRESH;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                amd_pkg::REG_PERIOD: r_cfg.sample_period_ms   <= pwdata[15:0];
                amd_pkg::REG_ALPHA:  r_cfg.filter_alpha       <= pwdata[15:0];
                amd_pkg::REG_THRESH: r_cfg.movement_threshold <= pwdata[23:0];
                default: begin
                    // unmapped slot: write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            amd_pkg::REG_PERIOD: prdata = {16'b0, r_cfg.sample_period_ms};
            amd_pkg::REG_ALPHA:  prdata = {16'b0, r_cfg.filter_alpha};
            amd_pkg::REG_THRESH: prdata = {8'b0, r_cfg.movement_threshold};
            default:             prdata = 32'b0;
        endcase
    end

    // ---------------- front: accept and classify ----------------
    amd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_elapsed_ms (i_elapsed_ms),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_read_ok    (i_read_ok),
        .i_cfg        (r_cfg),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in)
    );

    assign full = q_full;

    // ---------------- command queue ----------------
    amd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // ---------------- back: sample engine ----------------
    amd_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_q_empty            (q_empty),
        .i_q_head             (q_head),
        .o_q_pop              (q_pop),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_movement           (o_movement),
        .o_sample_taken       (o_sample_taken),
        .o_read_failed        (o_read_failed),
        .o_filtered_magnitude (o_filtered_magnitude)
    );

endmodule
